### hw/rtl/bsp_pkg.sv
// ============================================================================
// bsp_pkg: shared types and constants for the cubic B-spline evaluator
// Fixed-point widths, item codes, register indexes and the structs that
// travel from the sequencer into the basis pipeline and on to the accumulator.
// ============================================================================
package bsp_pkg;

    localparam int FRAC_W  = 24;
    localparam int COEF_W  = 24;
    localparam int POS_W   = 24;
    localparam int IDX_W   = 10;
    localparam int DIFF_W  = 25;
    localparam int U_W     = 49;
    localparam int N_W     = 25;
    localparam int BND_W   = 27;
    localparam int Z_W     = 51;
    localparam int T_W     = 26;
    localparam int SQ_W    = 27;
    localparam int CUBE_W  = 28;
    localparam int T1_W    = 25;
    localparam int SQ2_W   = 25;
    localparam int C2_W    = 25;
    localparam int PHI_W   = 27;
    localparam int B_W     = 29;
    localparam int PROD_W  = 53;
    localparam int ACC_W   = 56;
    localparam int RND_W   = 32;
    localparam int SUM_W   = 33;

    localparam int PIPE_LAT = 8;
    localparam int CNT_W    = $clog2(PIPE_LAT + 1);

    localparam logic [T_W-1:0] ONE_Q = T_W'(1) << FRAC_W;
    localparam logic [T_W-1:0] TWO_Q = T_W'(2) << FRAC_W;

    localparam logic [IDX_W-1:0] MIN_LAST = IDX_W'(3);

    localparam logic signed [SUM_W-1:0] Y_MAX = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0] Y_MIN = -SUM_W'(8388608);

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        CFG_ORIGIN = 2'd0,
        CFG_RECIP  = 2'd1,
        CFG_LAST   = 2'd2,
        CFG_OFFSET = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        W_NONE = 2'd0,
        W_ONE  = 2'd1,
        W_FOUR = 2'd2
    } wsel_t;

    typedef struct packed {
        logic                  valid;
        wsel_t                 wsel;
        logic signed [Z_W-1:0] zm;
        logic signed [Z_W-1:0] zb;
    } term_t;

    typedef struct packed {
        logic                  valid;
        logic signed [B_W-1:0] basis;
    } basis_t;

endpackage

### hw/rtl/bsp_coef_mem.sv
// ============================================================================
// bsp_coef_mem: coefficient store
// One write port and one read port with registered read data. Slots beyond
// the store drop writes and read as zero.
// ============================================================================
module bsp_coef_mem
    import bsp_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [IDX_W-1:0]         wr_index,
    input  logic signed [COEF_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [IDX_W-1:0]         rd_index,
    output logic signed [COEF_W-1:0] rd_data
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int EXT_W  = 17;

    logic signed [COEF_W-1:0] mem [DEPTH];
    logic signed [COEF_W-1:0] q_reg;
    logic                     ok_reg;

    logic [EXT_W-1:0]  wr_ext;
    logic [EXT_W-1:0]  rd_ext;
    logic              wr_ok;
    logic              rd_ok;

    assign wr_ext = EXT_W'(wr_index);
    assign rd_ext = EXT_W'(rd_index);
    assign wr_ok  = wr_ext < EXT_W'(DEPTH);
    assign rd_ok  = rd_ext < EXT_W'(DEPTH);

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_ok)
        begin
            mem[wr_ext[ADDR_W-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            q_reg  <= mem[rd_ext[ADDR_W-1:0]];
            ok_reg <= rd_ok;
        end
    end

    assign rd_data = ok_reg ? q_reg : '0;

endmodule

### hw/rtl/bsp_basis.sv
// ============================================================================
// bsp_basis: knot basis pipeline
// Six stages: two lanes evaluate the cubic kernel at the knot offset and at
// the phantom knot offset, then the boundary weight folds them together.
// ============================================================================
module bsp_basis
    import bsp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  term_t  term_i,
    output basis_t basis_o
);

    logic  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    wsel_t w1_reg, w2_reg, w3_reg, w4_reg, w5_reg;

    logic [T_W-1:0]          t1_reg   [2];
    logic [1:0]              zero1_reg;
    logic [T_W-1:0]          t2_reg   [2];
    logic [SQ_W-1:0]         sq2_reg  [2];
    logic [T1_W-1:0]         tm2_reg  [2];
    logic [1:0]              has2_reg;
    logic [1:0]              zero2_reg;
    logic [CUBE_W-1:0]       c1_3_reg [2];
    logic [SQ2_W-1:0]        sqm3_reg [2];
    logic [T1_W-1:0]         tm3_reg  [2];
    logic [1:0]              has3_reg;
    logic [1:0]              zero3_reg;
    logic [CUBE_W-3:0]       p1_4_reg [2];
    logic [C2_W-1:0]         c2_4_reg [2];
    logic [1:0]              has4_reg;
    logic [1:0]              zero4_reg;
    logic signed [PHI_W-1:0] phi5_reg [2];
    logic signed [B_W-1:0]   b6_reg;

    logic signed [Z_W-1:0]   z_lane   [2];
    logic [Z_W-1:0]          a_lane   [2];
    logic [T_W-1:0]          t1_next  [2];
    logic [1:0]              zero1_next;
    logic [2*T_W-1:0]        p_sq     [2];
    logic [SQ_W-1:0]         sq2_next [2];
    logic [T1_W-1:0]         tm2_next [2];
    logic [1:0]              has2_next;
    logic [SQ_W+T_W-1:0]     p_c1     [2];
    logic [2*T1_W-1:0]       p_sqm    [2];
    logic [CUBE_W-1:0]       c1_3_next[2];
    logic [SQ2_W-1:0]        sqm3_next[2];
    logic [SQ2_W+T1_W-1:0]   p_c2     [2];
    logic [C2_W-1:0]         c2_4_next[2];
    logic signed [PHI_W-1:0] phi5_next[2];
    logic signed [B_W-1:0]   pm_ext;
    logic signed [B_W-1:0]   pb_ext;
    logic signed [B_W-1:0]   b6_next;

    always_comb
    begin
        z_lane[0] = term_i.zm;
        z_lane[1] = term_i.zb;
        for (int k = 0; k < 2; k++)
        begin
            a_lane[k]     = z_lane[k][Z_W-1] ? Z_W'(-z_lane[k]) : Z_W'(z_lane[k]);
            zero1_next[k] = |a_lane[k][Z_W-1:FRAC_W+1];
            t1_next[k]    = TWO_Q - {1'b0, a_lane[k][FRAC_W:0]};

            p_sq[k]       = t1_reg[k] * t1_reg[k];
            sq2_next[k]   = p_sq[k][FRAC_W+SQ_W-1:FRAC_W];
            has2_next[k]  = t1_reg[k] > ONE_Q;
            tm2_next[k]   = t1_reg[k][T1_W-1:0] - ONE_Q[T1_W-1:0];

            p_c1[k]       = sq2_reg[k] * t2_reg[k];
            c1_3_next[k]  = p_c1[k][FRAC_W+CUBE_W-1:FRAC_W];
            p_sqm[k]      = tm2_reg[k] * tm2_reg[k];
            sqm3_next[k]  = p_sqm[k][FRAC_W+SQ2_W-1:FRAC_W];

            p_c2[k]       = sqm3_reg[k] * tm3_reg[k];
            c2_4_next[k]  = p_c2[k][FRAC_W+C2_W-1:FRAC_W];

            if (zero4_reg[k])
            begin
                phi5_next[k] = '0;
            end
            else if (has4_reg[k])
            begin
                phi5_next[k] = $signed({1'b0, p1_4_reg[k]}) - $signed({2'b00, c2_4_reg[k]});
            end
            else
            begin
                phi5_next[k] = $signed({1'b0, p1_4_reg[k]});
            end
        end

        pm_ext = B_W'(phi5_reg[0]);
        pb_ext = B_W'(phi5_reg[1]);
        unique case (w5_reg)
            W_ONE:   b6_next = pm_ext - pb_ext;
            W_FOUR:  b6_next = pm_ext - (pb_ext <<< 2);
            default: b6_next = pm_ext;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= term_i.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        w1_reg    <= term_i.wsel;
        w2_reg    <= w1_reg;
        w3_reg    <= w2_reg;
        w4_reg    <= w3_reg;
        w5_reg    <= w4_reg;
        zero1_reg <= zero1_next;
        zero2_reg <= zero1_reg;
        zero3_reg <= zero2_reg;
        zero4_reg <= zero3_reg;
        has2_reg  <= has2_next;
        has3_reg  <= has2_reg;
        has4_reg  <= has3_reg;
        for (int k = 0; k < 2; k++)
        begin
            t1_reg[k]   <= t1_next[k];
            t2_reg[k]   <= t1_reg[k];
            sq2_reg[k]  <= sq2_next[k];
            tm2_reg[k]  <= tm2_next[k];
            c1_3_reg[k] <= c1_3_next[k];
            sqm3_reg[k] <= sqm3_next[k];
            tm3_reg[k]  <= tm2_reg[k];
            p1_4_reg[k] <= c1_3_reg[k][CUBE_W-1:2];
            c2_4_reg[k] <= c2_4_next[k];
            phi5_reg[k] <= phi5_next[k];
        end
        b6_reg <= b6_next;
    end

    assign basis_o.valid = v6_reg;
    assign basis_o.basis = b6_reg;

endmodule

### hw/rtl/bsp_mac.sv
// ============================================================================
// bsp_mac: coefficient multiply-accumulate
// Multiply each coefficient by its knot basis, then add into the Q.40 sum.
// ============================================================================
module bsp_mac
    import bsp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     clear,
    input  basis_t                   basis_i,
    input  logic signed [COEF_W-1:0] coef_i,
    output logic signed [ACC_W-1:0]  acc_o
);

    logic                     pv_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;

    assign prod_next = coef_i * basis_i.basis;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            pv_reg <= basis_i.valid;
            if (clear)
            begin
                acc_reg <= '0;
            end
            else if (pv_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign acc_o = acc_reg;

endmodule

### hw/rtl/cubic_bspline_evaluator.sv
// ============================================================================
// cubic_bspline_evaluator: uniform cubic B-spline evaluator
// Coefficient store, knot sequencer, basis pipeline and accumulator.
// ============================================================================
// A load request writes a signed Q8.16 coefficient into the store. An
// evaluate request maps the Q16.8 position onto the knot grid, walks the up
// to four coefficients around it through a single memory read port, one per
// cycle, and weights each by its cubic basis in a basis and
// multiply-accumulate pipeline. With 1 to 4 knots in range the result
// lands in the output register and ready rises again in the same cycle; with
// no knot in range no coefficient is read. A new request is taken while a
// result waits to be read; the sequencer stalls only when a second result
// would overwrite it, for as long as that result waits. Origin, reciprocal,
// last knot and offset are read while an evaluation runs: write config only
// with no request in flight.
// ============================================================================
module cubic_bspline_evaluator
    import bsp_pkg::*;
#(
    parameter int MAX_COEFS = 1024
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [23:0]              cfg_data,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     op,
    input  logic [IDX_W-1:0]         coef_index,
    input  logic signed [COEF_W-1:0] coef_value,
    input  logic signed [POS_W-1:0]  x_pos,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [COEF_W-1:0] y_value,
    output logic                     saturated
);

    localparam int RD_LAT = 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_TRUNC,
        S_BOUNDS,
        S_ISSUE,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t                    state_reg, state_next;
    logic signed [POS_W-1:0]   origin_reg, origin_next;
    logic [23:0]               recip_reg, recip_next;
    logic [IDX_W-1:0]          last_reg, last_next;
    logic signed [COEF_W-1:0]  offset_reg, offset_next;
    logic signed [DIFF_W-1:0]  diff_reg, diff_next;
    logic signed [U_W-1:0]     u_reg, u_next;
    logic signed [N_W-1:0]     n_reg, n_next;
    logic [IDX_W-1:0]          i_reg, i_next;
    logic [IDX_W-1:0]          hi_reg, hi_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [RND_W-1:0]   r_reg, r_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [COEF_W-1:0]  y_reg, y_next;
    logic                      sat_reg, sat_next;
    term_t                     term_reg, term_next;
    logic [IDX_W-1:0]          iss_idx_reg, iss_idx_next;
    logic [RD_LAT-1:0]         rd_v_reg;
    logic [IDX_W-1:0]          rd_idx_reg [RD_LAT];

    logic                      in_fire;
    logic                      cfg_fire;
    logic                      eval_fire;
    logic                      load_fire;
    logic [IDX_W-1:0]          m_eff;
    logic signed [2*DIFF_W-1:0] u_prod;
    logic signed [BND_W-1:0]   n_ext, nm1, np2, m_ext, lo_b, hi_b;
    logic signed [Z_W-1:0]     u_ext, zb_lo, zb_hi;
    logic [IDX_W:0]            m_plus1;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [SUM_W-1:0]   y_sum;
    logic signed [COEF_W-1:0]  rd_data;
    basis_t                    basis;

    assign cfg_ready = 1'b1;
    assign in_ready  = state_reg == S_IDLE;
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign eval_fire = in_fire && (op_t'(op) == OP_EVAL);
    assign load_fire = in_fire && (op_t'(op) == OP_LOAD);

    assign m_eff   = (last_reg < MIN_LAST) ? MIN_LAST : last_reg;
    assign m_plus1 = {1'b0, m_eff} + (IDX_W+1)'(1);
    assign u_prod  = diff_reg * $signed({1'b0, recip_reg});

    assign n_ext = BND_W'(n_reg);
    assign nm1   = n_ext - BND_W'(1);
    assign np2   = n_ext + BND_W'(2);
    assign m_ext = $signed({{(BND_W-IDX_W){1'b0}}, m_eff});
    assign lo_b  = nm1[BND_W-1] ? '0 : nm1;
    assign hi_b  = (np2 > m_ext) ? m_ext : np2;

    assign u_ext = Z_W'(u_reg);
    assign zb_lo = u_ext + $signed(Z_W'(ONE_Q));
    assign zb_hi = u_ext - $signed(Z_W'({m_plus1, {FRAC_W{1'b0}}}));

    assign acc_rnd = acc + (ACC_W'(1) <<< (FRAC_W - 1));
    assign y_sum   = SUM_W'(r_reg) + SUM_W'(offset_reg);

    always_comb
    begin
        state_next     = state_reg;
        origin_next    = origin_reg;
        recip_next     = recip_reg;
        last_next      = last_reg;
        offset_next    = offset_reg;
        diff_next      = diff_reg;
        u_next         = u_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        hi_next        = hi_reg;
        cnt_next       = cnt_reg;
        r_next         = r_reg;
        out_valid_next = out_valid_reg;
        y_next         = y_reg;
        sat_next       = sat_reg;
        term_next      = term_reg;
        term_next.valid = 1'b0;
        iss_idx_next   = iss_idx_reg;

        if (cfg_fire)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ORIGIN: origin_next = $signed(cfg_data);
                CFG_RECIP:  recip_next  = cfg_data;
                CFG_LAST:   last_next   = cfg_data[IDX_W-1:0];
                CFG_OFFSET: offset_next = $signed(cfg_data);
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (eval_fire)
                begin
                    diff_next  = DIFF_W'(x_pos) - DIFF_W'(origin_reg);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                u_next     = u_prod[U_W-1:0];
                state_next = S_TRUNC;
            end
            S_TRUNC:
            begin
                n_next = $signed(u_reg[U_W-1:FRAC_W])
                       + $signed(N_W'(u_reg[U_W-1] && (|u_reg[FRAC_W-1:0])));
                state_next = S_BOUNDS;
            end
            S_BOUNDS:
            begin
                if (lo_b > hi_b)
                begin
                    cnt_next   = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    i_next     = lo_b[IDX_W-1:0];
                    hi_next    = hi_b[IDX_W-1:0];
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                term_next.valid = 1'b1;
                term_next.zm    = u_ext - $signed(Z_W'({i_reg, {FRAC_W{1'b0}}}));
                term_next.zb    = (i_reg < IDX_W'(2)) ? zb_lo : zb_hi;
                iss_idx_next    = i_reg;
                priority if (i_reg == '0)
                    term_next.wsel = W_FOUR;
                else if (i_reg == IDX_W'(1))
                    term_next.wsel = W_ONE;
                else if (i_reg == m_eff - IDX_W'(1))
                    term_next.wsel = W_ONE;
                else if (i_reg == m_eff)
                    term_next.wsel = W_FOUR;
                else
                    term_next.wsel = W_NONE;
                if (i_reg == hi_reg)
                begin
                    cnt_next   = CNT_W'(PIPE_LAT);
                    state_next = S_DRAIN;
                end
                else
                begin
                    i_next = i_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (cnt_reg == '0)
                begin
                    r_next     = acc_rnd[ACC_W-1:FRAC_W];
                    state_next = S_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    if (y_sum > Y_MAX)
                    begin
                        y_next   = Y_MAX[COEF_W-1:0];
                        sat_next = 1'b1;
                    end
                    else if (y_sum < Y_MIN)
                    begin
                        y_next   = Y_MIN[COEF_W-1:0];
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        y_next   = y_sum[COEF_W-1:0];
                        sat_next = 1'b0;
                    end
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            origin_reg    <= '0;
            recip_reg     <= 24'd65536;
            last_reg      <= MIN_LAST;
            offset_reg    <= '0;
            diff_reg      <= '0;
            u_reg         <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            hi_reg        <= '0;
            cnt_reg       <= '0;
            r_reg         <= '0;
            out_valid_reg <= 1'b0;
            y_reg         <= '0;
            sat_reg       <= 1'b0;
            term_reg      <= '0;
            iss_idx_reg   <= '0;
            rd_v_reg      <= '0;
            for (int k = 0; k < RD_LAT; k++)
            begin
                rd_idx_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            origin_reg    <= origin_next;
            recip_reg     <= recip_next;
            last_reg      <= last_next;
            offset_reg    <= offset_next;
            diff_reg      <= diff_next;
            u_reg         <= u_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            hi_reg        <= hi_next;
            cnt_reg       <= cnt_next;
            r_reg         <= r_next;
            out_valid_reg <= out_valid_next;
            y_reg         <= y_next;
            sat_reg       <= sat_next;
            term_reg      <= term_next;
            iss_idx_reg   <= iss_idx_next;
            rd_v_reg      <= {rd_v_reg[RD_LAT-2:0], term_reg.valid};
            rd_idx_reg[0] <= iss_idx_reg;
            for (int k = 1; k < RD_LAT; k++)
            begin
                rd_idx_reg[k] <= rd_idx_reg[k-1];
            end
        end
    end

    bsp_coef_mem #(
        .DEPTH (MAX_COEFS)
    ) u_mem (
        .clk      (clk),
        .wr_en    (load_fire),
        .wr_index (coef_index),
        .wr_data  (coef_value),
        .rd_en    (rd_v_reg[RD_LAT-1]),
        .rd_index (rd_idx_reg[RD_LAT-1]),
        .rd_data  (rd_data)
    );

    bsp_basis u_basis (
        .clk     (clk),
        .rst_n   (rst_n),
        .term_i  (term_reg),
        .basis_o (basis)
    );

    bsp_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (eval_fire),
        .basis_i (basis),
        .coef_i  (rd_data),
        .acc_o   (acc)
    );

    assign out_valid = out_valid_reg;
    assign y_value   = y_reg;
    assign saturated = sat_reg;

endmodule

### tb/cubic_bspline_evaluator_test.sv
// ============================================================================
// cubic_bspline_evaluator_test: self-checking bench for the spline evaluator
// Loads coefficients and evaluates positions under a series of register
// settings. A built-in fixed-point spline model predicts every result, and
// each result the block returns is compared in order against that prediction.
// Random idle and backpressure bursts are applied on both sides.
// ============================================================================
module cubic_bspline_evaluator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bsp_pkg::*;

    localparam int     STORE_DEPTH   = 1024;
    localparam longint UNIT_Q24      = 64'sd1 << 24;
    localparam int     SETTLE_CYCLES = 24;
    localparam longint CYCLE_LIMIT   = 500000;
    localparam int     RANDOM_ITEMS  = 1420;
    localparam int     FINAL_ITEMS   = 120;

    typedef struct {
        logic signed [COEF_W-1:0] y;
        logic                     sat;
    } spline_out_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    cfg_idx_t                 cfg_index;
    logic [23:0]              cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    op_t                      op;
    logic [IDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [POS_W-1:0]  x_pos;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [COEF_W-1:0] y_value;
    logic                     saturated;

    longint      knot_origin_q;
    longint      recip_q;
    longint      last_q;
    longint      offset_q;
    longint      coef_mem [STORE_DEPTH];
    bit          coef_written [STORE_DEPTH];
    spline_out_t pending_results [$];
    spline_out_t checked_result;

    int     error_count;
    int     load_count;
    int     eval_count;
    int     result_count;
    int     sat_count;
    int     setting_count;
    int     stall_left;
    longint cycle_count;
    bit     bursts_on;

    cubic_bspline_evaluator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .x_pos      (x_pos),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .y_value    (y_value),
        .saturated  (saturated)
    );

    always #2 clk = ~clk;

    function automatic longint cube_q24(input longint v);
        longint sq;
        sq = (v * v) >>> 24;
        return (sq * v) >>> 24;
    endfunction

    function automatic longint cubic_basis(input longint z);
        longint a;
        longint t;
        longint y;
        a = (z < 0) ? -z : z;
        if (a >= 2 * UNIT_Q24)
            return 0;
        t = 2 * UNIT_Q24 - a;
        y = cube_q24(t) >>> 2;
        if (t > UNIT_Q24)
            y -= cube_q24(t - UNIT_Q24);
        return y;
    endfunction

    function automatic longint knot_weight(input longint u, input longint m,
                                           input longint top);
        longint b;
        b = cubic_basis(u - m * UNIT_Q24);
        if (m == 0)
            b -= 4 * cubic_basis(u + UNIT_Q24);
        else if (m == 1)
            b -= cubic_basis(u + UNIT_Q24);
        else if (m == top - 1)
            b -= cubic_basis(u - (top + 1) * UNIT_Q24);
        else if (m == top)
            b -= 4 * cubic_basis(u - (top + 1) * UNIT_Q24);
        return b;
    endfunction

    function automatic longint top_knot();
        return (last_q < 3) ? 3 : last_q;
    endfunction

    function automatic longint grid_position(input logic signed [POS_W-1:0] pos);
        return (longint'(pos) - knot_origin_q) * recip_q;
    endfunction

    function automatic void knot_span(input logic signed [POS_W-1:0] pos,
                                      output longint lo, output longint hi);
        longint u;
        longint n;
        u = grid_position(pos);
        n = (u >= 0) ? (u >>> 24) : -((-u) >>> 24);
        lo = (n - 1 < 0) ? 0 : n - 1;
        hi = (n + 2 > top_knot()) ? top_knot() : n + 2;
    endfunction

    function automatic spline_out_t predict_spline(input logic signed [POS_W-1:0] pos);
        spline_out_t r;
        longint      u;
        longint      lo;
        longint      hi;
        longint      i;
        longint      acc;
        longint      y;
        u = grid_position(pos);
        knot_span(pos, lo, hi);
        acc = 0;
        for (i = lo; i <= hi; i++)
            acc += coef_mem[i] * knot_weight(u, i, top_knot());
        y = ((acc + (64'sd1 <<< 23)) >>> 24) + offset_q;
        r.sat = 1'b0;
        if (y > 8388607)
        begin
            y = 8388607;
            r.sat = 1'b1;
        end
        else if (y < -8388608)
        begin
            y = -8388608;
            r.sat = 1'b1;
        end
        r.y = y[COEF_W-1:0];
        return r;
    endfunction

    function automatic logic signed [COEF_W-1:0] random_coef();
        case ($urandom_range(0, 7))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2, 3:    return 24'(int'($urandom_range(0, 131072)) - 65536);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic signed [POS_W-1:0] target_position();
        longint u24;
        longint pos;
        if (recip_q == 0 || $urandom_range(0, 9) == 0)
            return 24'($urandom);
        if ($urandom_range(0, 4) == 0)
            u24 = (longint'($urandom_range(0, top_knot() + 4)) - 2) * UNIT_Q24;
        else
            u24 = longint'($urandom_range(0, (top_knot() + 7) * 4096)) * 4096
                  - 3 * UNIT_Q24;
        pos = knot_origin_q + u24 / recip_q;
        if (pos > 8388607 || pos < -8388608)
            return 24'($urandom);
        return 24'(pos);
    endfunction

    task automatic send_request(input op_t kind, input logic [IDX_W-1:0] slot,
                                input logic signed [COEF_W-1:0] value,
                                input logic signed [POS_W-1:0] pos);
        if (bursts_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= kind;
        coef_index <= slot;
        coef_value <= value;
        x_pos      <= pos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (kind == OP_LOAD)
        begin
            coef_mem[slot]     = longint'(value);
            coef_written[slot] = 1'b1;
            load_count++;
        end
        else
        begin
            pending_results.insert(pending_results.size(), predict_spline(pos));
            if (pending_results[$].sat)
                sat_count++;
            eval_count++;
        end
    endtask

    // fill any unwritten slot in range before the evaluate request
    task automatic eval_at(input logic signed [POS_W-1:0] pos);
        longint lo;
        longint hi;
        longint i;
        knot_span(pos, lo, hi);
        for (i = lo; i <= hi; i++)
            if (!coef_written[i])
                send_request(OP_LOAD, IDX_W'(i), random_coef(), 24'($urandom));
        send_request(OP_EVAL, IDX_W'($urandom), 24'($urandom), pos);
    endtask

    task automatic random_request();
        logic [IDX_W-1:0] slot;
        if ($urandom_range(0, 6) == 0)
        begin
            if ($urandom_range(0, 1) == 1)
                slot = IDX_W'($urandom_range(0, STORE_DEPTH - 1));
            else
                slot = IDX_W'($urandom_range(0, top_knot()));
            send_request(OP_LOAD, slot, random_coef(), 24'($urandom));
        end
        else
            eval_at(target_position());
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_idx_t sel, input logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (sel)
            CFG_ORIGIN: knot_origin_q = longint'($signed(data));
            CFG_RECIP:  recip_q       = longint'(data);
            CFG_LAST:   last_q        = longint'(data[IDX_W-1:0]);
            CFG_OFFSET: offset_q      = longint'($signed(data));
            default:    ;
        endcase
    endtask

    task automatic apply_setting(input logic [23:0] origin_bits,
                                 input logic [23:0] recip_bits,
                                 input logic [23:0] last_bits,
                                 input logic [23:0] offset_bits);
        drain_results();
        write_register(CFG_ORIGIN, origin_bits);
        write_register(CFG_RECIP, recip_bits);
        write_register(CFG_LAST, last_bits);
        write_register(CFG_OFFSET, offset_bits);
        cfg_valid <= 1'b0;
        setting_count++;
    endtask

    task automatic test_reset_defaults();
        send_request(OP_LOAD, 10'd0, 24'h7FFFFF, 24'($urandom));
        send_request(OP_LOAD, 10'd1, 24'h800000, 24'($urandom));
        send_request(OP_LOAD, 10'd2, 24'h7FFFFF, 24'($urandom));
        send_request(OP_LOAD, 10'd3, 24'h800000, 24'($urandom));
        send_request(OP_LOAD, 10'd1023, random_coef(), 24'($urandom));
        eval_at(24'sd0);
        eval_at(24'sd128);
        eval_at(24'sd256);
        eval_at(24'sd512);
        eval_at(-24'sd1);
        eval_at(24'h7FFFFF);
        eval_at(24'h800000);
    endtask

    task automatic test_corner_settings();
        apply_setting(24'h800000, 24'h000000, {14'h2AAA, 10'd1}, 24'h7FFFFF);
        eval_at(24'($urandom));
        apply_setting(24'h7FFFFF, 24'hFFFFFF, 24'd3, 24'h800000);
        eval_at(24'h800000);
        eval_at(24'h7FFFFF);
        apply_setting(24'h000000, 24'h000001, 24'd1023, 24'h000000);
        eval_at(24'h7FFFFF);
    endtask

    task automatic test_random_settings();
        logic [23:0] origin_bits;
        logic [23:0] recip_bits;
        logic [23:0] offset_bits;
        int          top;
        while (load_count + eval_count < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 4))
                0:       origin_bits = 24'h000000;
                1:       origin_bits = 24'h800000;
                2:       origin_bits = 24'h7FFFFF;
                3:       origin_bits = 24'(int'($urandom_range(0, 8192)) - 4096);
                default: origin_bits = 24'($urandom);
            endcase
            case ($urandom_range(0, 6))
                0:       recip_bits = 24'd65536;
                1:       recip_bits = 24'd0;
                2:       recip_bits = 24'd1;
                3:       recip_bits = 24'hFFFFFF;
                4, 5:    recip_bits = 24'($urandom_range(4096, 1 << 20));
                default: recip_bits = 24'($urandom);
            endcase
            case ($urandom_range(0, 15))
                0:       top = 1023;
                1:       top = $urandom_range(0, 2);
                2, 3:    top = $urandom_range(13, 1023);
                default: top = $urandom_range(3, 12);
            endcase
            case ($urandom_range(0, 7))
                0:       offset_bits = 24'h800000;
                1:       offset_bits = 24'h7FFFFF;
                2, 3:    offset_bits = 24'h000000;
                4:       offset_bits = 24'($urandom);
                default: offset_bits = 24'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            endcase
            apply_setting(origin_bits, recip_bits, {14'($urandom), 10'(top)}, offset_bits);
            bursts_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(15, 45))
            begin
                random_request();
                if ($urandom_range(0, 99) == 0)
                    drain_results();
            end
        end
    endtask

    task automatic test_back_to_back();
        bursts_on = 1'b0;
        apply_setting(24'(int'($urandom_range(0, 8192)) - 4096), 24'd65536,
                      24'($urandom_range(3, 8)), 24'($urandom));
        repeat (FINAL_ITEMS)
            random_request();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (bursts_on && $urandom_range(0, 5) == 0)
                stall_left <= $urandom_range(1, 4);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result y_value %0d saturated %0b",
                         $time, y_value, saturated);
            end
            else
            begin
                checked_result = pending_results.pop_front();
                if (y_value !== checked_result.y)
                begin
                    error_count++;
                    $display("%0t: y_value expected %0d actual %0d",
                             $time, checked_result.y, y_value);
                end
                if (saturated !== checked_result.sat)
                begin
                    error_count++;
                    $display("%0t: saturated expected %0b actual %0b",
                             $time, checked_result.sat, saturated);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: no completion after %0d cycles", $time, cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_ORIGIN;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        op         <= OP_LOAD;
        coef_index <= '0;
        coef_value <= '0;
        x_pos      <= '0;
        bursts_on     = 1'b1;
        knot_origin_q = 0;
        recip_q       = 65536;
        last_q        = 3;
        offset_q      = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_corner_settings();
        test_random_settings();
        test_back_to_back();
        drain_results();

        $display("Ran %0d coefficient loads and %0d evaluations over %0d register settings.",
                 load_count, eval_count, setting_count);
        $display("Checked %0d results, %0d of them clamped to range.",
                 result_count, sat_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
